[rtl/oatt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package oatt_pkg;

  // Channel layout: left, front, right.
  localparam int NCH  = 3;
  localparam int CH_W = 2;
  localparam logic [CH_W-1:0] CH_LEFT  = 2'd0;
  localparam logic [CH_W-1:0] CH_RIGHT = 2'd2;

  // Storage widths.
  localparam int SUM_W = 18;
  localparam int CNT_W = 5;
  localparam int THR_W = 15;
  localparam int HIT_W = 8;

  // Configuration port.
  localparam int REG_W = 12;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_ADAPT_ENABLE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEVIATION_LIMIT = 3'd1;
  localparam logic [IDX_W-1:0] REG_STABLE_LENGTH   = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRIG_BIAS       = 3'd3;
  localparam logic [IDX_W-1:0] REG_LEVEL_FLOOR     = 3'd4;
  localparam logic [IDX_W-1:0] REG_RAISE_STEP      = 3'd5;
  localparam logic [IDX_W-1:0] REG_HIT_RUN_LIMIT   = 3'd6;
  localparam logic [IDX_W-1:0] REG_NEAR_MARGIN     = 3'd7;

  localparam logic [REG_W-1:0] RST_DEVIATION_LIMIT = 12'd50;
  localparam logic [CNT_W-1:0] RST_STABLE_LENGTH   = 5'd15;
  localparam logic [REG_W-1:0] RST_TRIG_BIAS       = 12'd300;
  localparam logic [REG_W-1:0] RST_LEVEL_FLOOR     = 12'd100;
  localparam logic [REG_W-1:0] RST_RAISE_STEP      = 12'd800;
  localparam logic [HIT_W-1:0] RST_HIT_RUN_LIMIT   = 8'd24;
  localparam logic [REG_W-1:0] RST_NEAR_MARGIN     = 12'd330;

  // Operation codes of an input word.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_RELOAD = 1'b1;

  // Signed working width: holds avg + 29 * bias-corrected level with room to spare.
  localparam int WORK_W = 22;
  typedef logic signed [WORK_W-1:0] work_t;
  typedef logic [THR_W-1:0] thr_t;

  localparam int THR_MAX     = 32767;
  localparam int THR_INIT    = 500;
  localparam int SPOT_OFFSET = 200;

  // Shared divider: 21-bit dividend, 6-bit divisor, three quotient bits a cycle.
  localparam int DIV_W     = 21;
  localparam int DVSR_W    = 6;
  localparam int DIV_STEPS = 3;
  localparam int DIV_CYC   = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);
  localparam logic [DVSR_W-1:0] STEP_DIV = 6'd30;

  typedef struct packed {
    logic             adapt_enable;
    logic [REG_W-1:0] deviation_limit;
    logic [CNT_W-1:0] stable_length;
    logic [REG_W-1:0] trig_bias;
    logic [REG_W-1:0] level_floor;
    logic [REG_W-1:0] raise_step;
    logic [HIT_W-1:0] hit_run_limit;
    logic [REG_W-1:0] near_margin;
  } cfg_t;

  // Clamp a signed working value into the threshold range.
  function automatic thr_t sat_thr(input work_t v);
    thr_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > work_t'(THR_MAX)) begin
      r = thr_t'(THR_MAX);
    end else begin
      r = v[THR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/oatt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sample channel: one word per sensor tick or threshold reload.
interface oatt_sample_if #(parameter int ADC_BITS = 12);
  logic                valid;
  logic                ready;
  logic                op;
  logic [ADC_BITS-1:0] obs_left;
  logic [ADC_BITS-1:0] obs_front;
  logic [ADC_BITS-1:0] obs_right;
  logic [ADC_BITS-1:0] sun_left;
  logic [ADC_BITS-1:0] sun_front;
  logic [ADC_BITS-1:0] sun_right;
  logic                hit_flag;

  modport source (
    output valid, op, obs_left, obs_front, obs_right,
    output sun_left, sun_front, sun_right, hit_flag,
    input  ready
  );
  modport sink (
    input  valid, op, obs_left, obs_front, obs_right,
    input  sun_left, sun_front, sun_right, hit_flag,
    output ready
  );
endinterface

// Result channel: flags and the three thresholds after the word is applied.
interface oatt_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  trig_status;
  logic        near_flag;
  logic [2:0]  spot_status;
  logic [14:0] thresh_left;
  logic [14:0] thresh_front;
  logic [14:0] thresh_right;

  modport source (
    output valid, trig_status, near_flag, spot_status,
    output thresh_left, thresh_front, thresh_right,
    input  ready
  );
  modport sink (
    input  valid, trig_status, near_flag, spot_status,
    input  thresh_left, thresh_front, thresh_right,
    output ready
  );
endinterface

`default_nettype wire

[rtl/oatt_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module oatt_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [oatt_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [oatt_pkg::REG_W-1:0] cfg_data,
  output oatt_pkg::cfg_t                 cfg
);

  // Register file, written one register at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adapt_enable    <= 1'b0;
      cfg.deviation_limit <= oatt_pkg::RST_DEVIATION_LIMIT;
      cfg.stable_length   <= oatt_pkg::RST_STABLE_LENGTH;
      cfg.trig_bias       <= oatt_pkg::RST_TRIG_BIAS;
      cfg.level_floor     <= oatt_pkg::RST_LEVEL_FLOOR;
      cfg.raise_step      <= oatt_pkg::RST_RAISE_STEP;
      cfg.hit_run_limit   <= oatt_pkg::RST_HIT_RUN_LIMIT;
      cfg.near_margin     <= oatt_pkg::RST_NEAR_MARGIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        oatt_pkg::REG_ADAPT_ENABLE:    cfg.adapt_enable    <= cfg_data[0];
        oatt_pkg::REG_DEVIATION_LIMIT: cfg.deviation_limit <= cfg_data;
        oatt_pkg::REG_STABLE_LENGTH:   cfg.stable_length   <= cfg_data[oatt_pkg::CNT_W-1:0];
        oatt_pkg::REG_TRIG_BIAS:       cfg.trig_bias       <= cfg_data;
        oatt_pkg::REG_LEVEL_FLOOR:     cfg.level_floor     <= cfg_data;
        oatt_pkg::REG_RAISE_STEP:      cfg.raise_step      <= cfg_data;
        oatt_pkg::REG_HIT_RUN_LIMIT:   cfg.hit_run_limit   <= cfg_data[oatt_pkg::HIT_W-1:0];
        oatt_pkg::REG_NEAR_MARGIN:     cfg.near_margin     <= cfg_data;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/oatt_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module oatt_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [oatt_pkg::DIV_W-1:0]  dividend,
  input  wire logic [oatt_pkg::DVSR_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [oatt_pkg::DIV_W-1:0]       quotient
);

  logic [oatt_pkg::DVSR_W-1:0]    rem;
  logic [oatt_pkg::DVSR_W-1:0]    rem_next;
  logic [oatt_pkg::DIV_W-1:0]     quo;
  logic [oatt_pkg::DIV_W-1:0]     quo_next;
  logic [oatt_pkg::DVSR_W-1:0]    dvsr;
  logic [oatt_pkg::DIV_CNT_W-1:0] cnt;

  // Restoring division, DIV_STEPS quotient bits per cycle. The dividend shifts out
  // of the top of quo while quotient bits shift in at the bottom.
  always_comb begin
    logic [oatt_pkg::DVSR_W:0]   trial;
    logic [oatt_pkg::DVSR_W-1:0] r;
    logic [oatt_pkg::DIV_W-1:0]  q;
    r = rem;
    q = quo;
    trial = '0;
    for (int k = 0; k < oatt_pkg::DIV_STEPS; k++) begin
      trial = {r, q[oatt_pkg::DIV_W-1]};
      q = {q[oatt_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr}) begin
        trial = trial - {1'b0, dvsr};
        q[0] = 1'b1;
      end
      r = trial[oatt_pkg::DVSR_W-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  // Control: run until the step counter reaches its last value, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == oatt_pkg::DIV_CNT_W'(oatt_pkg::DIV_CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

  // A new division never starts on top of a running one.
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

  // Done follows a busy run and ends it.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("divider done without a run");

  // The final remainder is below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) done |-> (rem < dvsr))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

[rtl/obstacle_adaptive_trigger_threshold_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Adaptive trigger thresholds for three infrared obstacle channels (left,
// front, right). Each sample word is either a tick, which feeds the running
// windows and pulls stable thresholds toward the window average when
// adaptation is on and raises tripped thresholds after a long run of hits, or
// a reload, which sets every threshold to its sample plus the trigger bias (at
// least 500). Every word gives one result word with trigger, near and spot
// flags and the thresholds after the word is applied. The channels are worked
// one after another through a single divider that yields three quotient bits
// a cycle. A result that is still waiting for the sink holds the block in its
// last state until the output register frees up. The block takes one word at
// a time and is ready again in the same cycle that a result is presented; a
// finished result sits in an output register, so the next word is accepted
// while it waits. Configuration registers may be written only while the block
// is idle.
module obstacle_adaptive_trigger_threshold_top #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [oatt_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [oatt_pkg::REG_W-1:0]  cfg_data,
  oatt_sample_if.sink                      sample,
  oatt_result_if.source                    result
);

  localparam int NCH   = oatt_pkg::NCH;
  localparam int THR_W = oatt_pkg::THR_W;
  localparam int SUM_W = oatt_pkg::SUM_W;
  localparam int CNT_W = oatt_pkg::CNT_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RELOAD    = 4'd1;
  localparam logic [3:0] S_AVG       = 4'd2;
  localparam logic [3:0] S_AVG_WAIT  = 4'd3;
  localparam logic [3:0] S_CHECK     = 4'd4;
  localparam logic [3:0] S_PULL      = 4'd5;
  localparam logic [3:0] S_STEP_WAIT = 4'd6;
  localparam logic [3:0] S_APPLY     = 4'd7;
  localparam logic [3:0] S_HIT       = 4'd8;
  localparam logic [3:0] S_FLAGS     = 4'd9;

  oatt_pkg::cfg_t cfg;

  logic [3:0]                    state;
  logic [oatt_pkg::CH_W-1:0]     ch;

  // Latched word.
  logic [ADC_BITS-1:0]           obs [NCH];
  logic [ADC_BITS-1:0]           sun [NCH];
  logic                          hit_r;

  // Persistent state.
  logic [SUM_W-1:0]              win_sum [NCH];
  logic [CNT_W-1:0]              win_cnt [NCH];
  logic [NCH-1:0][THR_W-1:0]     thr;
  logic [oatt_pkg::HIT_W-1:0]    hit_run;

  // Per-channel scratch.
  logic [SUM_W-1:0]              s_r;
  logic [CNT_W:0]                c_r;
  logic [SUM_W-1:0]              avg_r;
  oatt_pkg::work_t               b_r;
  oatt_pkg::work_t               nb_r;
  logic                          neg_r;

  // Output register.
  logic                          out_valid;
  logic [NCH-1:0]                trig_o;
  logic [NCH-1:0]                spot_o;
  logic                          near_o;
  logic [NCH-1:0][THR_W-1:0]     thr_o;

  // Divider hookup.
  logic                          div_start;
  logic [oatt_pkg::DIV_W-1:0]    div_dividend;
  logic [oatt_pkg::DVSR_W-1:0]   div_divisor;
  logic                          div_busy;
  logic                          div_done;
  logic [oatt_pkg::DIV_W-1:0]    div_quo;

  // Combinational datapath.
  logic [SUM_W-1:0]              s_sum;
  logic [CNT_W:0]                c_inc;
  oatt_pkg::work_t               x_w;
  oatt_pkg::work_t               avg_w;
  oatt_pkg::work_t               diff_w;
  oatt_pkg::work_t               abs_d;
  oatt_pkg::work_t               b_w;
  oatt_pkg::work_t               half_sum;
  oatt_pkg::work_t               half_nb;
  oatt_pkg::work_t               step_num;
  oatt_pkg::work_t               step_mag;
  oatt_pkg::work_t               nb_floor;
  logic                          restart;
  logic                          do_update;
  logic                          half_cond;
  logic                          last_ch;
  logic [oatt_pkg::HIT_W-1:0]    hit_inc;
  logic [NCH-1:0]                trig_c;
  logic [NCH-1:0]                spot_c;
  logic                          near_c;
  logic                          accept;
  logic                          out_free;

  oatt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  oatt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign out_free     = !out_valid || result.ready;
  assign last_ch      = (ch == oatt_pkg::CH_W'(NCH - 1));

  // Window arithmetic for the current channel.
  always_comb begin
    s_sum    = win_sum[ch] + SUM_W'(obs[ch]);
    c_inc    = (CNT_W + 1)'(win_cnt[ch]) + (CNT_W + 1)'(1);
    x_w      = oatt_pkg::work_t'(obs[ch]);
    avg_w    = oatt_pkg::work_t'(avg_r);
    diff_w   = avg_w - x_w;
    abs_d    = (diff_w < 0) ? -diff_w : diff_w;
    restart  = abs_d > oatt_pkg::work_t'(cfg.deviation_limit);
    b_w      = oatt_pkg::work_t'(thr[ch]) - oatt_pkg::work_t'(cfg.trig_bias);
    do_update = c_r > (CNT_W + 1)'(cfg.stable_length);
    // Left and front also take the half step when the average is above the level.
    half_cond = (oatt_pkg::work_t'(sun[ch]) > b_r) ||
                ((ch != oatt_pkg::CH_RIGHT) && (b_r < avg_w));
    // Halving that truncates toward zero.
    half_sum = avg_w + b_r;
    half_nb  = (half_sum + oatt_pkg::work_t'(half_sum[oatt_pkg::WORK_W-1])) >>> 1;
    // avg + 29 * b as shifts and adds.
    step_num = avg_w + (b_r <<< 5) - (b_r <<< 1) - b_r;
    step_mag = (step_num < 0) ? -step_num : step_num;
    nb_floor = (nb_r < oatt_pkg::work_t'(cfg.level_floor)) ?
               oatt_pkg::work_t'(cfg.level_floor) : nb_r;
    hit_inc  = hit_run + 1'b1;
  end

  // Divider requests: window average, then the slow pull step.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = oatt_pkg::DIV_W'(s_sum);
    div_divisor  = oatt_pkg::DVSR_W'(c_inc);
    if (state == S_AVG) begin
      div_start = 1'b1;
    end else if ((state == S_PULL) && do_update && !half_cond) begin
      div_start    = 1'b1;
      div_dividend = step_mag[oatt_pkg::DIV_W-1:0];
      div_divisor  = oatt_pkg::STEP_DIV;
    end
  end

  // Result flags from the final thresholds.
  always_comb begin
    oatt_pkg::work_t o_w;
    oatt_pkg::work_t t_w;
    near_c = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      o_w = oatt_pkg::work_t'(obs[i]);
      t_w = oatt_pkg::work_t'(thr[i]);
      trig_c[i] = o_w > t_w;
      spot_c[i] = o_w > (t_w + oatt_pkg::work_t'(oatt_pkg::SPOT_OFFSET));
      if (o_w > (t_w - oatt_pkg::work_t'(cfg.near_margin))) begin
        near_c = 1'b1;
      end
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch        <= '0;
      hit_run   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        win_sum[i] <= '0;
        win_cnt[i] <= '0;
        thr[i]     <= THR_W'(oatt_pkg::THR_INIT);
      end
    end else begin
      // The flags state refills the output register itself.
      if (out_valid && result.ready && (state != S_FLAGS)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ch <= oatt_pkg::CH_LEFT;
            if (sample.op == oatt_pkg::OP_RELOAD) begin
              state <= S_RELOAD;
            end else if (cfg.adapt_enable) begin
              state <= S_AVG;
            end else begin
              state <= S_HIT;
            end
          end
        end
        S_RELOAD: begin
          for (int i = 0; i < NCH; i++) begin
            if (oatt_pkg::work_t'(obs[i]) + oatt_pkg::work_t'(cfg.trig_bias) <
                oatt_pkg::work_t'(oatt_pkg::THR_INIT)) begin
              thr[i] <= THR_W'(oatt_pkg::THR_INIT);
            end else begin
              thr[i] <= oatt_pkg::sat_thr(oatt_pkg::work_t'(obs[i]) +
                                          oatt_pkg::work_t'(cfg.trig_bias));
            end
          end
          state <= S_FLAGS;
        end
        S_AVG: begin
          state <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= S_PULL;
        end
        S_PULL: begin
          win_sum[ch] <= s_r;
          if (do_update) begin
            win_cnt[ch] <= '0;
            state <= half_cond ? S_APPLY : S_STEP_WAIT;
          end else begin
            win_cnt[ch] <= c_r[CNT_W-1:0];
            if (last_ch) begin
              state <= S_HIT;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_AVG;
            end
          end
        end
        S_STEP_WAIT: begin
          if (div_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          thr[ch] <= oatt_pkg::sat_thr(nb_floor + oatt_pkg::work_t'(cfg.trig_bias));
          if (last_ch) begin
            state <= S_HIT;
          end else begin
            ch    <= ch + 1'b1;
            state <= S_AVG;
          end
        end
        S_HIT: begin
          if (hit_r) begin
            if (hit_inc > cfg.hit_run_limit) begin
              hit_run <= '0;
              for (int i = 0; i < NCH; i++) begin
                if (oatt_pkg::work_t'(obs[i]) > oatt_pkg::work_t'(thr[i])) begin
                  thr[i] <= oatt_pkg::sat_thr(oatt_pkg::work_t'(thr[i]) +
                                              oatt_pkg::work_t'(cfg.raise_step));
                end
              end
            end else begin
              hit_run <= hit_inc;
            end
          end else begin
            hit_run <= '0;
          end
          state <= S_FLAGS;
        end
        S_FLAGS: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Word capture and per-channel scratch registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      obs[0] <= sample.obs_left[ADC_BITS-1:0];
      obs[1] <= sample.obs_front[ADC_BITS-1:0];
      obs[2] <= sample.obs_right[ADC_BITS-1:0];
      sun[0] <= sample.sun_left[ADC_BITS-1:0];
      sun[1] <= sample.sun_front[ADC_BITS-1:0];
      sun[2] <= sample.sun_right[ADC_BITS-1:0];
      hit_r  <= sample.hit_flag;
    end
    if (state == S_AVG) begin
      s_r <= s_sum;
      c_r <= c_inc;
    end
    if ((state == S_AVG_WAIT) && div_done) begin
      avg_r <= div_quo[SUM_W-1:0];
    end
    if (state == S_CHECK) begin
      b_r <= b_w;
      if (restart) begin
        s_r <= '0;
        c_r <= '0;
      end
    end
    if (state == S_PULL) begin
      nb_r  <= half_nb;
      neg_r <= step_num < 0;
    end
    if ((state == S_STEP_WAIT) && div_done) begin
      nb_r <= neg_r ? -oatt_pkg::work_t'(div_quo) : oatt_pkg::work_t'(div_quo);
    end
    if ((state == S_FLAGS) && out_free) begin
      trig_o <= trig_c;
      spot_o <= spot_c;
      near_o <= near_c;
      thr_o  <= thr;
    end
  end

  // Result channel. The thresholds are copied into the output register so the
  // payload holds while the next word is in work.
  assign result.valid        = out_valid;
  assign result.trig_status  = trig_o;
  assign result.spot_status  = spot_o;
  assign result.near_flag    = near_o;
  assign result.thresh_left  = thr_o[0];
  assign result.thresh_front = thr_o[1];
  assign result.thresh_right = thr_o[2];

  // An accepted word always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted word did not start work");

  // Thresholds move only in the apply, reload and hit states.
  a_thr_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == S_APPLY || state == S_RELOAD || state == S_HIT) |=> $stable(thr))
    else $error("threshold changed outside an update state");

  // A reload leaves every threshold at or above the initial level.
  a_reload_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_RELOAD) |=>
      (thr[0] >= THR_W'(oatt_pkg::THR_INIT)) &&
      (thr[1] >= THR_W'(oatt_pkg::THR_INIT)) &&
      (thr[2] >= THR_W'(oatt_pkg::THR_INIT)))
    else $error("reload left a threshold below the initial level");

  // The divider is never running while the sequencer waits for a word.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider busy while the block is idle");

endmodule

`default_nettype wire
